/* src/hotkey_chord_sequence_detector_defines.svh */
// ----------------------------------------------------------------------------
// Hotkey detector assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef HOTKEY_CHORD_SEQUENCE_DETECTOR_DEFINES_SVH
`define HOTKEY_CHORD_SEQUENCE_DETECTOR_DEFINES_SVH

// implication checked on every clock outside reset
`define HK_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hotkey check failed");

// next-cycle implication checked outside reset
`define HK_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hotkey check failed");

`endif

/* src/hcsd_pkg.sv */
// ----------------------------------------------------------------------------
// Hotkey detector package
// Shared codes, constants and widths.
// ----------------------------------------------------------------------------
`default_nettype none
package hcsd_pkg;
  localparam int BUTTONS_DEF     = 64;
  localparam int CHORD_SLOTS_DEF = 16;
  localparam int SEQ_SLOTS_DEF   = 16;
  localparam int SEQ_MAX_LEN_DEF = 8;
  localparam logic [15:0] MAX_WINDOW_RST = 16'd1000;

  localparam logic [2:0] CMD_PRESS  = 3'd0;
  localparam logic [2:0] CMD_ADD    = 3'd1;
  localparam logic [2:0] CMD_REMOVE = 3'd2;
  localparam logic [2:0] CMD_CLEAR  = 3'd3;
  localparam logic [2:0] CMD_RESET  = 3'd4;

  localparam logic [1:0] ST_NONE = 2'd0;
  localparam logic [1:0] ST_HIT  = 2'd1;
  localparam logic [1:0] ST_OK   = 2'd2;
  localparam logic [1:0] ST_REJ  = 2'd3;
endpackage
`default_nettype wire

/* src/hotkey_chord_sequence_detector.sv */
// A result strobe follows the request's dispatch state and, for a press, its table scans:
//   the chord table, the sequence table for a child (twice on a restart from the root)
//   and the sequence table for a full match, one slot at a time.
// One request at a time; busy is high from acceptance until the strobe cycle,
//   in which the next request may be accepted. Synchronous active-high reset clears key
//   state, used bits and the prefix; table payload memories are not cleared.
`default_nettype none
module hotkey_chord_sequence_detector #(
  parameter int BUTTONS     = hcsd_pkg::BUTTONS_DEF,
  parameter int CHORD_SLOTS = hcsd_pkg::CHORD_SLOTS_DEF,
  parameter int SEQ_SLOTS   = hcsd_pkg::SEQ_SLOTS_DEF,
  parameter int SEQ_MAX_LEN = hcsd_pkg::SEQ_MAX_LEN_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  cmd,
  input  wire logic [5:0]  button,
  input  wire logic [7:0]  binding_id,
  input  wire logic        kind,
  input  wire logic        last,
  input  wire logic [31:0] press_time,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data,
  output logic             done,
  output logic [1:0]       status,
  output logic [7:0]       hit_id,
  output logic             hit_kind
);
  import hcsd_pkg::*;

  localparam int CW = (CHORD_SLOTS > 1) ? $clog2(CHORD_SLOTS) : 1;
  localparam int SW = (SEQ_SLOTS > 1) ? $clog2(SEQ_SLOTS) : 1;
  localparam int LW = $clog2(SEQ_MAX_LEN + 1);
  localparam int KW = 6 * SEQ_MAX_LEN;
  localparam int CCW = $clog2(CHORD_SLOTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_CHORD, S_CHILD, S_WIN, S_FULL, S_CCOMMIT,
    S_SCOMMIT, S_REM, S_SHIFT, S_DONE
  } state_t;

  state_t state;

  // registered request
  logic [2:0]  r_cmd;
  logic [5:0]  r_button;
  logic [7:0]  r_id;
  logic        r_kind, r_last;
  logic [31:0] r_time;

  logic [15:0] max_window;
  logic [BUTTONS-1:0] key_down;
  logic [KW-1:0] prefix_keys;
  logic [LW-1:0] prefix_len;
  logic [31:0] window_start;
  logic [BUTTONS-1:0] pending_keys;
  logic [KW-1:0] pend_list;
  logic [LW-1:0] pend_count;
  logic pend_over, pend_bad;

  // chord memory: mask and owner, compacted; count of live entries
  logic [BUTTONS-1:0] chord_mask [CHORD_SLOTS];
  logic [7:0]         chord_owner[CHORD_SLOTS];
  logic [CCW-1:0]     chord_cnt;
  logic [CW-1:0]      c_raddr;
  logic [BUTTONS-1:0] c_rmask;
  logic [7:0]         c_rowner;
  logic               c_we;
  logic [CW-1:0]      c_waddr;
  logic [BUTTONS-1:0] c_wmask;
  logic [7:0]         c_wowner;

  // sequence memory
  logic [KW-1:0]  seq_keys [SEQ_SLOTS];
  logic [LW-1:0]  seq_len  [SEQ_SLOTS];
  logic [7:0]     seq_owner[SEQ_SLOTS];
  logic [SEQ_SLOTS-1:0] seq_used;
  logic [SW-1:0]  s_raddr;
  logic [KW-1:0]  s_rkeys;
  logic [LW-1:0]  s_rlen;
  logic [7:0]     s_rowner;
  logic           s_we;
  logic [SW-1:0]  s_waddr;
  logic [KW-1:0]  s_wkeys;
  logic [LW-1:0]  s_wlen;
  logic [7:0]     s_wowner;

  always_ff @(posedge clk) begin
    c_rmask  <= chord_mask[c_raddr];
    c_rowner <= chord_owner[c_raddr];
    if (c_we) begin
      chord_mask[c_waddr]  <= c_wmask;
      chord_owner[c_waddr] <= c_wowner;
    end
  end

  always_ff @(posedge clk) begin
    s_rkeys  <= seq_keys[s_raddr];
    s_rlen   <= seq_len[s_raddr];
    s_rowner <= seq_owner[s_raddr];
    if (s_we) begin
      seq_keys[s_waddr]  <= s_wkeys;
      seq_len[s_waddr]   <= s_wlen;
      seq_owner[s_waddr] <= s_wowner;
    end
  end

  // scan counter: address issued; rd_ok marks that data of idx-1 is valid
  logic [6:0] idx;
  logic       rd_ok;
  logic [SW-1:0] s_prev;
  logic found;          // child found / match found
  logic pass2;          // child search after restart from root
  logic [SW-1:0] free_slot;
  logic free_ok;

  assign c_raddr = idx[CW-1:0];
  assign s_raddr = idx[SW-1:0];
  assign s_prev  = SW'(idx - 7'd1);

  // per-entry comparisons on the registered read data
  logic pfx_match, child_hit, full_hit, reg_clash;
  logic [LW-1:0] mlen;
  always_comb begin
    pfx_match = 1'b1;
    for (int i = 0; i < SEQ_MAX_LEN; i++)
      if (LW'(i) < prefix_len && s_rkeys[6*i +: 6] != prefix_keys[6*i +: 6])
        pfx_match = 1'b0;
    child_hit = 1'b0;
    for (int i = 0; i < SEQ_MAX_LEN; i++)
      if (LW'(i) == prefix_len && s_rkeys[6*i +: 6] == r_button)
        child_hit = 1'b1;
    child_hit = child_hit && pfx_match && (s_rlen > prefix_len)
                && seq_used[s_prev];
    full_hit = seq_used[s_prev] && pfx_match && (s_rlen == prefix_len);
    mlen = (s_rlen < pend_count) ? s_rlen : pend_count;
    reg_clash = 1'b1;
    for (int i = 0; i < SEQ_MAX_LEN; i++)
      if (LW'(i) < mlen && s_rkeys[6*i +: 6] != pend_list[6*i +: 6])
        reg_clash = 1'b0;
  end

  logic chord_full_hit;
  assign chord_full_hit = ((c_rmask & ~key_down) == '0);
  logic [31:0] elapsed;
  assign elapsed = r_time - window_start;

  // commit end: the commit state finishes this cycle, pending list is dropped
  logic commit_end;
  always_comb begin
    commit_end = 1'b0;
    if (state == S_CCOMMIT)
      commit_end = (rd_ok && c_rowner == r_id) || pend_bad ||
                   7'(idx) >= 7'(chord_cnt);
    else if (state == S_SCOMMIT)
      commit_end = pend_bad || pend_over || pend_count == '0 ||
                   (rd_ok && seq_used[s_prev] && (s_rowner == r_id || reg_clash)) ||
                   (idx == 7'(SEQ_SLOTS) && rd_ok);
  end

  assign busy = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !start;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      max_window <= MAX_WINDOW_RST;
      key_down <= '0;
      prefix_keys <= '0;
      prefix_len <= '0;
      window_start <= '0;
      pending_keys <= '0;
      pend_list <= '0;
      pend_count <= '0;
      pend_over <= 1'b0;
      pend_bad <= 1'b0;
      chord_cnt <= '0;
      seq_used <= '0;
      done <= 1'b0;
      status <= ST_NONE;
      hit_id <= '0;
      hit_kind <= 1'b0;
      idx <= '0;
      rd_ok <= 1'b0;
      found <= 1'b0;
      pass2 <= 1'b0;
      free_ok <= 1'b0;
      free_slot <= '0;
      c_we <= 1'b0;
      s_we <= 1'b0;
      c_waddr <= '0;
      c_wmask <= '0;
      c_wowner <= '0;
      s_waddr <= '0;
      s_wkeys <= '0;
      s_wlen <= '0;
      s_wowner <= '0;
      r_cmd <= '0; r_button <= '0; r_id <= '0; r_kind <= 1'b0;
      r_last <= 1'b0; r_time <= '0;
    end else begin
      done <= 1'b0;
      c_we <= 1'b0;
      s_we <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cfg_valid && cfg_ready) max_window <= cfg_data;
          if (start) begin
            r_cmd <= cmd; r_button <= button; r_id <= binding_id;
            r_kind <= kind; r_last <= last; r_time <= press_time;
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          idx <= '0;
          rd_ok <= 1'b0;
          found <= 1'b0;
          pass2 <= 1'b0;
          free_ok <= 1'b0;
          hit_id <= '0;
          hit_kind <= 1'b0;
          case (r_cmd)
            CMD_PRESS: begin
              if (32'(r_button) >= BUTTONS) begin
                status <= ST_NONE;
                state <= S_DONE;
              end else begin
                key_down[r_button] <= 1'b1;
                state <= S_CHORD;
              end
            end
            CMD_ADD: begin
              if (32'(r_button) >= BUTTONS) pend_bad <= 1'b1;
              else pending_keys[r_button] <= 1'b1;
              if (pend_count < LW'(SEQ_MAX_LEN)) begin
                pend_list[6*pend_count +: 6] <= r_button;
                pend_count <= pend_count + 1'b1;
              end else begin
                pend_over <= 1'b1;
              end
              if (!r_last) begin
                status <= ST_OK;
                state <= S_DONE;
              end else begin
                state <= r_kind ? S_SCOMMIT : S_CCOMMIT;
              end
            end
            CMD_REMOVE: begin
              prefix_len <= '0;
              state <= S_REM;
            end
            CMD_CLEAR: begin
              chord_cnt <= '0;
              seq_used <= '0;
              pending_keys <= '0; pend_list <= '0; pend_count <= '0;
              pend_over <= 1'b0; pend_bad <= 1'b0;
              prefix_len <= '0;
              status <= ST_OK;
              state <= S_DONE;
            end
            CMD_RESET: begin
              key_down <= '0;
              prefix_len <= '0;
              status <= ST_OK;
              state <= S_DONE;
            end
            default: begin
              status <= ST_REJ;
              state <= S_DONE;
            end
          endcase
        end
        S_CHORD: begin
          // compacted: live entries are 0..chord_cnt-1
          if (rd_ok && chord_full_hit) begin
            prefix_len <= '0;
            status <= ST_HIT; hit_id <= c_rowner; hit_kind <= 1'b0;
            state <= S_DONE;
          end else if (7'(idx) >= 7'(chord_cnt)) begin
            idx <= '0; rd_ok <= 1'b0;
            state <= S_CHILD;
          end else begin
            idx <= idx + 7'd1;
            rd_ok <= 1'b1;
          end
        end
        S_CHILD: begin
          if (rd_ok && child_hit && prefix_len < LW'(SEQ_MAX_LEN)) found <= 1'b1;
          if (idx == 7'(SEQ_SLOTS) && rd_ok) begin
            idx <= '0; rd_ok <= 1'b0;
            if (found || (child_hit && prefix_len < LW'(SEQ_MAX_LEN))) begin
              if (pass2 || prefix_len == '0) window_start <= r_time;
              state <= S_WIN;
            end else if (!pass2) begin
              prefix_len <= '0;
              pass2 <= 1'b1;
              found <= 1'b0;
            end else begin
              status <= ST_NONE;
              state <= S_DONE;
            end
          end else begin
            idx <= idx + 7'd1;
            rd_ok <= 1'b1;
          end
        end
        S_WIN: begin
          if (elapsed > 32'(max_window)) begin
            prefix_len <= '0;
            status <= ST_NONE;
            state <= S_DONE;
          end else begin
            prefix_keys[6*prefix_len +: 6] <= r_button;
            prefix_len <= prefix_len + 1'b1;
            idx <= '0; rd_ok <= 1'b0;
            state <= S_FULL;
          end
        end
        S_FULL: begin
          if (rd_ok && full_hit) begin
            prefix_len <= '0;
            status <= ST_HIT; hit_id <= s_rowner; hit_kind <= 1'b1;
            state <= S_DONE;
          end else if (idx == 7'(SEQ_SLOTS) && rd_ok) begin
            status <= ST_NONE;
            state <= S_DONE;
          end else begin
            idx <= idx + 7'd1;
            rd_ok <= 1'b1;
          end
        end
        S_CCOMMIT: begin
          if (rd_ok && c_rowner == r_id) begin
            status <= ST_REJ;
            state <= S_DONE;
          end else if (pend_bad || 7'(idx) >= 7'(chord_cnt)) begin
            if (pend_bad || chord_cnt == CCW'(CHORD_SLOTS)) begin
              status <= ST_REJ;
            end else begin
              c_we <= 1'b1;
              c_waddr <= CW'(chord_cnt);
              c_wmask <= pending_keys;
              c_wowner <= r_id;
              chord_cnt <= chord_cnt + 1'b1;
              status <= ST_OK;
            end
            state <= S_DONE;
          end else begin
            idx <= idx + 7'd1;
            rd_ok <= 1'b1;
          end
        end
        S_SCOMMIT: begin
          if (rd_ok && !seq_used[s_prev] && !free_ok) begin
            free_ok <= 1'b1; free_slot <= s_prev;
          end
          if (pend_bad || pend_over || pend_count == '0 ||
              (rd_ok && seq_used[s_prev] && (s_rowner == r_id || reg_clash))) begin
            status <= ST_REJ;
            state <= S_DONE;
          end else if (idx == 7'(SEQ_SLOTS) && rd_ok) begin
            if (free_ok || !seq_used[s_prev]) begin
              // write data held here, the pending list is dropped this edge
              s_we <= 1'b1;
              s_waddr <= free_ok ? free_slot : s_prev;
              s_wkeys <= pend_list;
              s_wlen <= pend_count;
              s_wowner <= r_id;
              seq_used[free_ok ? free_slot : s_prev] <= 1'b1;
              status <= ST_OK;
            end else begin
              status <= ST_REJ;
            end
            state <= S_DONE;
          end else begin
            idx <= idx + 7'd1;
            rd_ok <= 1'b1;
          end
        end
        S_REM: begin
          if (!r_kind) begin
            if (rd_ok && c_rowner == r_id) begin
              // read of the entry after the hole is already issued
              idx <= idx + 7'd1;
              state <= S_SHIFT;
            end else if (7'(idx) >= 7'(chord_cnt)) begin
              status <= ST_REJ; state <= S_DONE;
            end else begin
              idx <= idx + 7'd1; rd_ok <= 1'b1;
            end
          end else begin
            if (rd_ok && seq_used[s_prev] && s_rowner == r_id) begin
              seq_used[s_prev] <= 1'b0;
              status <= ST_OK; state <= S_DONE;
            end else if (idx == 7'(SEQ_SLOTS) && rd_ok) begin
              status <= ST_REJ; state <= S_DONE;
            end else begin
              idx <= idx + 7'd1; rd_ok <= 1'b1;
            end
          end
        end
        S_SHIFT: begin
          // read data holds entry idx-1; move it down into idx-2
          if (7'(idx) > 7'(chord_cnt)) begin
            chord_cnt <= chord_cnt - 1'b1;
            status <= ST_OK; state <= S_DONE;
          end else begin
            c_we <= 1'b1;
            c_waddr <= CW'(idx - 7'd2);
            c_wmask <= c_rmask;
            c_wowner <= c_rowner;
            idx <= idx + 7'd1;
          end
        end
        S_DONE: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (commit_end) begin
        pending_keys <= '0; pend_list <= '0; pend_count <= '0;
        pend_over <= 1'b0; pend_bad <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

/* src/hcsd_checker.sv */
// ----------------------------------------------------------------------------
// Hotkey detector port checker
// Watches request and result behaviour on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hotkey_chord_sequence_detector_defines.svh"
module hcsd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done,
  input wire logic [1:0] status,
  input wire logic [7:0] hit_id,
  input wire logic       hit_kind
);
  import hcsd_pkg::*;

  `HK_ASSERT_NXT(a_start_busy, clk, rst, start && !busy, busy)
  `HK_ASSERT_NXT(a_done_once, clk, rst, done, !done)
  `HK_ASSERT_IMP(a_hit_zero, clk, rst, done && status != ST_HIT, hit_id == 8'd0 && !hit_kind)
  `HK_ASSERT_IMP(a_done_idle, clk, rst, done, !busy)
endmodule

bind hotkey_chord_sequence_detector hcsd_checker u_hcsd_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .status(status), .hit_id(hit_id), .hit_kind(hit_kind)
);
`default_nettype wire

/* bench/hotkey_chord_sequence_detector_tb.sv */
// ----------------------------------------------------------------------------
// Hotkey chord and sequence detector testbench
// Drives press, registration, remove, clear and reset requests with random
// gaps, predicts each result from a behavioural copy of the detector and
// compares every strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module hotkey_chord_sequence_detector_tb;
  import hcsd_pkg::*;

  localparam int NBTN   = BUTTONS_DEF;
  localparam int NCHORD = CHORD_SLOTS_DEF;
  localparam int NSEQ   = SEQ_SLOTS_DEF;
  localparam int SEQLEN = SEQ_MAX_LEN_DEF;
  localparam int WDOG_LIMIT = 20000;
  localparam int SETTLE = 80;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [5:0]  button;
    logic [7:0]  binding_id;
    logic        kind;
    logic        last;
    logic [31:0] press_time;
  } hk_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] hit_id;
    logic       hit_kind;
  } hk_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [2:0]  cmd = '0;
  logic [5:0]  button = '0;
  logic [7:0]  binding_id = '0;
  logic        kind = 1'b0;
  logic        last = 1'b0;
  logic [31:0] press_time = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        done;
  logic [1:0]  status;
  logic [7:0]  hit_id;
  logic        hit_kind;

  hotkey_chord_sequence_detector i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .button(button), .binding_id(binding_id), .kind(kind),
    .last(last), .press_time(press_time),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .status(status), .hit_id(hit_id), .hit_kind(hit_kind)
  );

  always #10 clk = ~clk;

  // ---- predictor state: a behavioural copy of the detector ----------------
  logic [15:0]       win_max;
  logic [NBTN-1:0]   keys_held;
  logic [NBTN-1:0]   chord_keys [NCHORD];
  logic [7:0]        chord_id   [NCHORD];
  logic              chord_live [NCHORD];
  logic [5:0]        seq_btn    [NSEQ][SEQLEN];
  int unsigned       seq_n      [NSEQ];
  logic [7:0]        seq_id     [NSEQ];
  logic              seq_live   [NSEQ];
  logic [5:0]        path_btn   [SEQLEN];
  int unsigned       path_n;
  logic [31:0]       path_t0;
  logic [NBTN-1:0]   reg_keys;
  logic [5:0]        reg_btn    [SEQLEN];
  int unsigned       reg_n;
  logic              reg_over;

  hk_req_t pending_reqs[$];
  hk_res_t expected_results[$];
  int      n_errors = 0;
  int      wdog = 0;
  logic    drive_hold = 1'b0;  // set by the initial block around config writes
  int      calm_left = 0;      // cycles left in a stretch without idling

  task automatic report_mismatch(input string what, input hk_res_t got, input hk_res_t exp);
    $display("%0t mismatch %s: got st=%0d id=%0d k=%0d exp st=%0d id=%0d k=%0d",
             $realtime, what, got.status, got.hit_id, got.hit_kind,
             exp.status, exp.hit_id, exp.hit_kind);
    n_errors++;
  endtask

  function automatic void detector_reset();
    win_max = MAX_WINDOW_RST;
    keys_held = '0;
    path_n = 0;
    path_t0 = '0;
    reg_keys = '0;
    reg_n = 0;
    reg_over = 1'b0;
    for (int i = 0; i < NCHORD; i++) chord_live[i] = 1'b0;
    for (int i = 0; i < NSEQ; i++) seq_live[i] = 1'b0;
  endfunction

  function automatic void drop_registration();
    reg_keys = '0;
    reg_n = 0;
    reg_over = 1'b0;
  endfunction

  function automatic bit path_matches(int s);
    if (seq_n[s] < path_n) return 0;
    for (int i = 0; i < path_n; i++)
      if (seq_btn[s][i] != path_btn[i]) return 0;
    return 1;
  endfunction

  function automatic bit can_extend(logic [5:0] b);
    if (path_n >= SEQLEN) return 0;
    for (int s = 0; s < NSEQ; s++)
      if (seq_live[s] && seq_n[s] > path_n && path_matches(s) && seq_btn[s][path_n] == b)
        return 1;
    return 0;
  endfunction

  function automatic hk_res_t mk_res(logic [1:0] st, logic [7:0] id, logic k);
    hk_res_t r;
    r.status = st;
    r.hit_id = id;
    r.hit_kind = k;
    return r;
  endfunction

  function automatic hk_res_t apply_press(logic [5:0] b, logic [31:0] t);
    keys_held[b] = 1'b1;
    // chords first, in registration order
    for (int c = 0; c < NCHORD; c++)
      if (chord_live[c] && (chord_keys[c] & ~keys_held) == '0) begin
        path_n = 0;
        return mk_res(ST_HIT, chord_id[c], 1'b0);
      end
    if (!can_extend(b)) begin
      path_n = 0;
      if (!can_extend(b)) return mk_res(ST_NONE, '0, 1'b0);
      path_t0 = t;
    end else if (path_n == 0) begin
      path_t0 = t;
    end
    if (t - path_t0 > {16'd0, win_max}) begin
      path_n = 0;
      return mk_res(ST_NONE, '0, 1'b0);
    end
    path_btn[path_n] = b;
    path_n++;
    for (int s = 0; s < NSEQ; s++)
      if (seq_live[s] && seq_n[s] == path_n && path_matches(s)) begin
        path_n = 0;
        return mk_res(ST_HIT, seq_id[s], 1'b1);
      end
    return mk_res(ST_NONE, '0, 1'b0);
  endfunction

  function automatic bit commit_chord(logic [7:0] id);
    int n;
    n = 0;
    for (int c = 0; c < NCHORD; c++)
      if (chord_live[c]) begin
        n++;
        if (chord_id[c] == id) return 0;
      end
    if (n >= NCHORD) return 0;
    chord_keys[n] = reg_keys;
    chord_id[n] = id;
    chord_live[n] = 1'b1;
    return 1;
  endfunction

  function automatic bit commit_seq(logic [7:0] id);
    int slot;
    int m;
    bit same;
    slot = -1;
    if (reg_over || reg_n == 0) return 0;
    for (int s = 0; s < NSEQ; s++) begin
      if (!seq_live[s]) begin
        if (slot < 0) slot = s;
        continue;
      end
      if (seq_id[s] == id) return 0;
      m = (seq_n[s] < reg_n) ? seq_n[s] : reg_n;
      same = 1;
      for (int i = 0; i < m; i++)
        if (seq_btn[s][i] != reg_btn[i]) same = 0;
      if (same) return 0;
    end
    if (slot < 0) return 0;
    for (int i = 0; i < SEQLEN; i++) seq_btn[slot][i] = reg_btn[i];
    seq_n[slot] = reg_n;
    seq_id[slot] = id;
    seq_live[slot] = 1'b1;
    return 1;
  endfunction

  function automatic bit remove_binding(logic [7:0] id, logic k);
    if (!k) begin
      for (int i = 0; i < NCHORD; i++)
        if (chord_live[i] && chord_id[i] == id) begin
          for (int j = i; j + 1 < NCHORD; j++) begin
            chord_keys[j] = chord_keys[j+1];
            chord_id[j] = chord_id[j+1];
            chord_live[j] = chord_live[j+1];
          end
          chord_live[NCHORD-1] = 1'b0;
          return 1;
        end
      return 0;
    end
    for (int i = 0; i < NSEQ; i++)
      if (seq_live[i] && seq_id[i] == id) begin
        seq_live[i] = 1'b0;
        return 1;
      end
    return 0;
  endfunction

  // Buttons are 6 bits wide with 64 buttons, so none is ever out of range.
  function automatic hk_res_t detector_step(hk_req_t q);
    bit ok;
    case (q.cmd)
      CMD_PRESS: return apply_press(q.button, q.press_time);
      CMD_ADD: begin
        reg_keys[q.button] = 1'b1;
        if (reg_n < SEQLEN) begin
          reg_btn[reg_n] = q.button;
          reg_n++;
        end else begin
          reg_over = 1'b1;
        end
        if (!q.last) return mk_res(ST_OK, '0, 1'b0);
        ok = q.kind ? commit_seq(q.binding_id) : commit_chord(q.binding_id);
        drop_registration();
        return mk_res(ok ? ST_OK : ST_REJ, '0, 1'b0);
      end
      CMD_REMOVE: begin
        ok = remove_binding(q.binding_id, q.kind);
        path_n = 0;
        return mk_res(ok ? ST_OK : ST_REJ, '0, 1'b0);
      end
      CMD_CLEAR: begin
        for (int i = 0; i < NCHORD; i++) chord_live[i] = 1'b0;
        for (int i = 0; i < NSEQ; i++) seq_live[i] = 1'b0;
        drop_registration();
        path_n = 0;
        return mk_res(ST_OK, '0, 1'b0);
      end
      CMD_RESET: begin
        keys_held = '0;
        path_n = 0;
        return mk_res(ST_OK, '0, 1'b0);
      end
      default: return mk_res(ST_REJ, '0, 1'b0);
    endcase
  endfunction

  // ---- stimulus builders --------------------------------------------------
  logic [31:0] clock_ticks = 32'd0;  // running press timestamp

  function automatic hk_req_t mk_req(logic [2:0] c, logic [5:0] b, logic [7:0] id,
                                     logic k, logic l, logic [31:0] t);
    hk_req_t q;
    q.cmd = c; q.button = b; q.binding_id = id; q.kind = k; q.last = l; q.press_time = t;
    return q;
  endfunction

  // append one request to the tail of the pending queue
  task automatic queue_req(hk_req_t q);
    pending_reqs.insert(pending_reqs.size(), q);
  endtask

  // Registration of n buttons from a small or full pool
  task automatic push_binding(logic k, int n, int pool, logic [7:0] id);
    for (int i = 0; i < n; i++)
      queue_req(mk_req(CMD_ADD, 6'($urandom_range(0, pool - 1)), id, k,
                       i == n - 1, $urandom));
  endtask

  task automatic push_press(logic [5:0] b, int step_max);
    clock_ticks += $urandom_range(0, step_max);
    queue_req(mk_req(CMD_PRESS, b, 8'($urandom), 1'($urandom), 1'($urandom),
                     clock_ticks));
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_window(logic [15:0] v);
    wait_idle();
    drive_hold <= 1'b1;
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    win_max = v;
    cfg_valid <= 1'b0;
    drive_hold <= 1'b0;
  endtask

  // One random phase: mostly well-formed bindings followed by presses that walk
  // registered sequences, with noise and broken registrations mixed in.
  task automatic push_random_phase(int n_items, int step_max);
    int base;
    int sel;
    int pool;
    base = pending_reqs.size();
    while (pending_reqs.size() - base < n_items) begin
      sel = $urandom_range(0, 99);
      pool = ($urandom_range(0, 9) == 0) ? 64 : 8;
      if (sel < 18) begin
        push_binding(1'($urandom), $urandom_range(1, ($urandom_range(0, 7) == 0) ? 10 : 4),
                     pool, 8'($urandom_range(0, ($urandom_range(0, 3) == 0) ? 255 : 12)));
      end else if (sel < 70) begin
        push_press(6'($urandom_range(0, pool - 1)), step_max);
      end else if (sel < 78) begin
        queue_req(mk_req(CMD_RESET, 6'($urandom), 8'($urandom), 1'($urandom),
                         1'($urandom), $urandom));
      end else if (sel < 86) begin
        queue_req(mk_req(CMD_REMOVE, 6'($urandom),
                         8'($urandom_range(0, 12)), 1'($urandom),
                         1'($urandom), $urandom));
      end else if (sel < 89) begin
        queue_req(mk_req(CMD_CLEAR, 6'($urandom), 8'($urandom), 1'($urandom),
                         1'($urandom), $urandom));
      end else if (sel < 91) begin
        queue_req(mk_req(3'($urandom_range(5, 7)), 6'($urandom), 8'($urandom),
                         1'($urandom), 1'($urandom), $urandom));
      end else begin
        // unfinished registration left pending across other requests
        queue_req(mk_req(CMD_ADD, 6'($urandom_range(0, pool - 1)),
                         8'($urandom), 1'($urandom), 1'b0, $urandom));
      end
    end
  endtask

  // ---- driver: one request at a time, start held until accepted ----------
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      // accepted at this edge; predict and move on
      expected_results.insert(expected_results.size(),
                              detector_step(pending_reqs.pop_front()));
      start <= 1'b0;
    end else if (!start && !drive_hold && pending_reqs.size() != 0 && !busy) begin
      if (calm_left > 0 || $urandom_range(0, 99) >= 24) begin
        cmd        <= pending_reqs[0].cmd;
        button     <= pending_reqs[0].button;
        binding_id <= pending_reqs[0].binding_id;
        kind       <= pending_reqs[0].kind;
        last       <= pending_reqs[0].last;
        press_time <= pending_reqs[0].press_time;
        start      <= 1'b1;
      end
    end
    if (calm_left > 0) calm_left <= calm_left - 1;
  end

  // ---- monitor: compare each strobe with the oldest prediction -----------
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", {status, hit_id, hit_kind}, '0);
      end else if ({status, hit_id, hit_kind} !== expected_results[0]) begin
        report_mismatch("field", {status, hit_id, hit_kind}, expected_results[0]);
        void'(expected_results.pop_front());
      end else begin
        void'(expected_results.pop_front());
      end
    end
  end

  // ---- watchdog: counts cycles in which no request or result moves -------
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_LIMIT) begin
      $display("FAIL hotkey_chord_sequence_detector");
      $finish;
    end
  end

  // ---- stimulus sequence ---------------------------------------------------
  initial begin
    detector_reset();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: chord, sequence, window abort, remove, reject cases
    push_binding(1'b0, 2, 2, 8'd0);                      // chord {0,1} or {0}/{1}
    queue_req(mk_req(CMD_ADD, 6'd63, 8'd255, 1'b1, 1'b0, 32'hFFFF_FFFF));
    queue_req(mk_req(CMD_ADD, 6'd62, 8'd255, 1'b1, 1'b1, 32'd0));
    queue_req(mk_req(CMD_ADD, 6'd63, 8'd7, 1'b1, 1'b1, 32'd0)); // prefix of seq
    queue_req(mk_req(CMD_PRESS, 6'd63, 8'd0, 1'b0, 1'b0, 32'hFFFF_FFF0));
    queue_req(mk_req(CMD_PRESS, 6'd62, 8'd0, 1'b0, 1'b0, 32'd5)); // wraps
    queue_req(mk_req(CMD_PRESS, 6'd63, 8'd0, 1'b0, 1'b0, 32'd100));
    queue_req(mk_req(CMD_PRESS, 6'd62, 8'd0, 1'b0, 1'b0, 32'd5000)); // too late
    queue_req(mk_req(CMD_PRESS, 6'd0, 8'd0, 1'b0, 1'b0, 32'd5001));
    queue_req(mk_req(CMD_PRESS, 6'd1, 8'd0, 1'b0, 1'b0, 32'd5002));
    queue_req(mk_req(CMD_RESET, 6'd0, 8'd0, 1'b0, 1'b0, 32'd0));
    push_binding(1'b1, 9, 4, 8'd9);                      // too long
    queue_req(mk_req(CMD_REMOVE, 6'd0, 8'd255, 1'b1, 1'b0, 32'd0));
    queue_req(mk_req(CMD_REMOVE, 6'd0, 8'd255, 1'b1, 1'b0, 32'd0));
    queue_req(mk_req(CMD_REMOVE, 6'd0, 8'd0, 1'b0, 1'b0, 32'd0));
    queue_req(mk_req(3'd7, 6'd0, 8'd0, 1'b0, 1'b0, 32'd0));
    queue_req(mk_req(CMD_CLEAR, 6'd0, 8'd0, 1'b0, 1'b1, 32'd0));
    @(negedge clk);
    calm_left <= 300;
    wait_idle();

    // random phases under several window settings, extremes included
    write_window(16'd0);
    push_random_phase(250, 3);
    write_window(16'hFFFF);
    clock_ticks = 32'hFFFF_0000;
    push_random_phase(350, 5000);
    write_window(16'd40);
    push_random_phase(350, 25);
    @(negedge clk);
    calm_left <= 400;
    write_window(16'($urandom));
    push_random_phase(400, 600);

    wait_idle();
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("PASS hotkey_chord_sequence_detector");
    end else begin
      $display("FAIL hotkey_chord_sequence_detector");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+src
src/hcsd_pkg.sv
src/hotkey_chord_sequence_detector.sv
src/hcsd_checker.sv
bench/hotkey_chord_sequence_detector_tb.sv
